// File: rtl/ccsr_pkg.sv
// ----------------------------------------------------------------------------
// ccsr_pkg
// Shared constants, register indexes and types of the CC/CV supply regulator.
// ----------------------------------------------------------------------------
package ccsr_pkg;

   localparam int VOLTAGE_STEP_MV = 50;
   localparam int GAIN_FRAC_BITS  = 8;

   localparam int DATA_W    = 16;
   localparam int ERR_W     = DATA_W + 1;
   localparam int COEF_W    = DATA_W + 2;
   localparam int PROD_W    = COEF_W + 1 + ERR_W;
   localparam int ACC_W     = 32;
   localparam int SUM_W     = PROD_W + 2;
   localparam int PID_OUT_W = ACC_W - GAIN_FRAC_BITS;
   localparam int TGT_W     = ((PID_OUT_W > ERR_W) ? PID_OUT_W : ERR_W) + 1;

   typedef enum logic [2:0] {
      CSR_GAIN_PROP       = 3'd0,
      CSR_GAIN_INTEG      = 3'd1,
      CSR_GAIN_DERIV      = 3'd2,
      CSR_CURRENT_LIMIT   = 3'd3,
      CSR_VOLTAGE_SETP    = 3'd4,
      CSR_VOLTAGE_FLOOR   = 3'd5,
      CSR_VOLTAGE_CEILING = 3'd6,
      CSR_CURRENT_HYST    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] gain_prop;
      logic [DATA_W-1:0] gain_integ;
      logic [DATA_W-1:0] gain_deriv;
      logic [DATA_W-1:0] current_limit_ma;
      logic [DATA_W-1:0] voltage_setpoint_mv;
      logic [DATA_W-1:0] voltage_floor_mv;
      logic [DATA_W-1:0] voltage_ceiling_mv;
      logic [DATA_W-1:0] current_hysteresis_ma;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_prop:             16'd256,
      gain_integ:            16'd0,
      gain_deriv:            16'd0,
      current_limit_ma:      16'd10000,
      voltage_setpoint_mv:   16'd3000,
      voltage_floor_mv:      16'd0,
      voltage_ceiling_mv:    16'd65535,
      current_hysteresis_ma: 16'd0
   };

   typedef struct packed {
      logic [DATA_W-1:0] current_ma;
      logic [DATA_W-1:0] voltage_mv;
      logic              adjust;
      logic              enabled;
   } item_type;

   typedef struct packed {
      logic update;
      logic clear;
   } pid_ctrl_type;

endpackage

// File: rtl/ccsr_csr.sv
// ----------------------------------------------------------------------------
// ccsr_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ccsr_csr
   import ccsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [DATA_W-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_PROP:       cfg_in.gain_prop             = csr_wdata;
            CSR_GAIN_INTEG:      cfg_in.gain_integ            = csr_wdata;
            CSR_GAIN_DERIV:      cfg_in.gain_deriv            = csr_wdata;
            CSR_CURRENT_LIMIT:   cfg_in.current_limit_ma      = csr_wdata;
            CSR_VOLTAGE_SETP:    cfg_in.voltage_setpoint_mv   = csr_wdata;
            CSR_VOLTAGE_FLOOR:   cfg_in.voltage_floor_mv      = csr_wdata;
            CSR_VOLTAGE_CEILING: cfg_in.voltage_ceiling_mv    = csr_wdata;
            CSR_CURRENT_HYST:    cfg_in.current_hysteresis_ma = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ccsr_pid.sv
// ----------------------------------------------------------------------------
// ccsr_pid
// Incremental PID on the current error with a saturating accumulator.
// ----------------------------------------------------------------------------
module ccsr_pid
   import ccsr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic [DATA_W-1:0]           current_ma,
   input  pid_ctrl_type                ctrl,
   output logic signed [PID_OUT_W-1:0] pid_out
);

   logic signed [ERR_W-1:0]  err_prev1_ff;
   logic signed [ERR_W-1:0]  err_prev1_in;
   logic signed [ERR_W-1:0]  err_prev2_ff;
   logic signed [ERR_W-1:0]  err_prev2_in;
   logic signed [ACC_W-1:0]  pid_accum_ff;
   logic signed [ACC_W-1:0]  pid_accum_in;

   logic signed [ERR_W-1:0]  err;
   logic [COEF_W-1:0]        coef0;
   logic [COEF_W-1:0]        coef1;
   logic signed [PROD_W-1:0] prod0;
   logic signed [PROD_W-1:0] prod1;
   logic signed [PROD_W-1:0] prod2;
   logic signed [SUM_W-1:0]  sum;
   logic signed [ACC_W-1:0]  acc_sat;

   always_comb begin
      err   = $signed({1'b0, cfg.current_limit_ma}) - $signed({1'b0, current_ma});
      coef0 = COEF_W'(cfg.gain_prop) + COEF_W'(cfg.gain_integ) + COEF_W'(cfg.gain_deriv);
      coef1 = COEF_W'(cfg.gain_prop) + COEF_W'({cfg.gain_deriv, 1'b0});
      prod0 = $signed({1'b0, coef0}) * err;
      prod1 = $signed({1'b0, coef1}) * err_prev1_ff;
      prod2 = $signed({1'b0, cfg.gain_deriv}) * err_prev2_ff;
      sum   = SUM_W'(pid_accum_ff) + SUM_W'(prod0) - SUM_W'(prod1) + SUM_W'(prod2);
      if (sum[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){1'b0}} ||
          sum[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){1'b1}}) begin
         acc_sat = sum[ACC_W-1:0];
      end else if (sum[SUM_W-1]) begin
         acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
      end
      pid_out = acc_sat[ACC_W-1:GAIN_FRAC_BITS];
   end

   always_comb begin
      err_prev1_in = err_prev1_ff;
      err_prev2_in = err_prev2_ff;
      pid_accum_in = pid_accum_ff;
      if (ctrl.clear) begin
         err_prev1_in = '0;
         err_prev2_in = '0;
         pid_accum_in = '0;
      end else if (ctrl.update) begin
         err_prev1_in = err;
         err_prev2_in = err_prev1_ff;
         pid_accum_in = acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_prev1_ff <= '0;
         err_prev2_ff <= '0;
         pid_accum_ff <= '0;
      end else begin
         err_prev1_ff <= err_prev1_in;
         err_prev2_ff <= err_prev2_in;
         pid_accum_ff <= pid_accum_in;
      end
   end

endmodule

// File: rtl/ccsr_ctrl.sv
// ----------------------------------------------------------------------------
// ccsr_ctrl
// Mode decision, target clamping and the constant-current mode register.
// ----------------------------------------------------------------------------
module ccsr_ctrl
   import ccsr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  item_type                    item,
   input  logic                        go,
   input  logic signed [PID_OUT_W-1:0] pid_out,
   output pid_ctrl_type                pid_ctrl,
   output logic                        target_valid,
   output logic [DATA_W-1:0]           target_mv,
   output logic                        mode_cc
);

   logic                    mode_ff;
   logic                    mode_in;

   logic                    request;
   logic                    over_limit;
   logic                    below_band;
   logic signed [ERR_W-1:0] vdiff;
   logic [ERR_W-1:0]        vdist;
   logic signed [TGT_W-1:0] cc_target;
   logic signed [TGT_W-1:0] floor_s;
   logic signed [TGT_W-1:0] ceil_s;
   logic signed [TGT_W-1:0] raised;
   logic signed [TGT_W-1:0] clamped;

   always_comb begin
      request    = item.adjust & item.enabled;
      over_limit = item.current_ma > cfg.current_limit_ma;
      below_band = ({1'b0, item.current_ma} + {1'b0, cfg.current_hysteresis_ma}) <
                   {1'b0, cfg.current_limit_ma};
      vdiff      = $signed({1'b0, item.voltage_mv}) - $signed({1'b0, cfg.voltage_setpoint_mv});
      vdist      = vdiff[ERR_W-1] ? ERR_W'(-vdiff) : ERR_W'(vdiff);
      cc_target  = TGT_W'(pid_out) + TGT_W'($signed({1'b0, item.voltage_mv}));
      floor_s    = TGT_W'($signed({1'b0, cfg.voltage_floor_mv}));
      ceil_s     = TGT_W'($signed({1'b0, cfg.voltage_ceiling_mv}));
      raised     = (cc_target < floor_s) ? floor_s : cc_target;
      clamped    = (raised > ceil_s) ? ceil_s : raised;
   end

   always_comb begin
      pid_ctrl     = '0;
      target_valid = 1'b0;
      target_mv    = '0;
      mode_in      = mode_ff;
      if (request) begin
         if (over_limit) begin
            mode_in         = 1'b1;
            pid_ctrl.update = go;
            target_valid    = 1'b1;
            target_mv       = clamped[DATA_W-1:0];
         end else if (below_band) begin
            mode_in        = 1'b0;
            pid_ctrl.clear = go;
            if (vdist > ERR_W'(VOLTAGE_STEP_MV)) begin
               target_valid = 1'b1;
               target_mv    = cfg.voltage_setpoint_mv;
            end
         end else begin
            mode_in = 1'b0;
            if (cfg.voltage_setpoint_mv < item.voltage_mv) begin
               target_valid = 1'b1;
               target_mv    = cfg.voltage_setpoint_mv;
            end
         end
      end
      mode_cc = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (go) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// File: rtl/cc_cv_supply_regulator_top.sv
// The regulator accepts one item per clock cycle while req_stall is low and
// returns exactly one result item for each. An accepted item is registered in
// the input register and its result in the result register, which holds it
// until the result side takes it. While an item waits in the input register,
// the mode decision, the three PID products, the saturating accumulator update
// and the voltage clamp are evaluated combinationally, and the result register
// and the PID and mode state are written at the same edge, so the next item
// already sees the new state. The input stalls only while a result is held off
// by the result side and another item waits in the input register. Configuration
// registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
// cc_cv_supply_regulator_top
// Constant-current / constant-voltage regulator with an incremental PID loop.
// ----------------------------------------------------------------------------
module cc_cv_supply_regulator_top
   import ccsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [DATA_W-1:0] csr_wdata,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_current_ma,
   input  logic [DATA_W-1:0] req_voltage_mv,
   input  logic              req_adjust,
   input  logic              req_enabled,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_target_valid,
   output logic [DATA_W-1:0] rsp_target_mv,
   output logic              rsp_mode_cc
);

   cfg_type                     cfg;
   pid_ctrl_type                pid_ctrl;
   logic signed [PID_OUT_W-1:0] pid_out;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   item_type                    in_item_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        out_target_valid_ff;
   logic [DATA_W-1:0]           out_target_mv_ff;
   logic                        out_mode_cc_ff;

   logic                        go;
   logic                        take;
   logic                        res_target_valid;
   logic [DATA_W-1:0]           res_target_mv;
   logic                        res_mode_cc;

   ccsr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ccsr_pid u_pid (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .current_ma (in_item_ff.current_ma),
      .ctrl       (pid_ctrl),
      .pid_out    (pid_out)
   );

   ccsr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item         (in_item_ff),
      .go           (go),
      .pid_out      (pid_out),
      .pid_ctrl     (pid_ctrl),
      .target_valid (res_target_valid),
      .target_mv    (res_target_mv),
      .mode_cc      (res_mode_cc)
   );

   always_comb begin
      go           = in_valid_ff & ~(out_valid_ff & rsp_stall);
      req_stall    = in_valid_ff & ~go;
      take         = req_valid & ~req_stall;
      in_valid_in  = take | (in_valid_ff & ~go);
      out_valid_in = go | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.current_ma <= req_current_ma;
         in_item_ff.voltage_mv <= req_voltage_mv;
         in_item_ff.adjust     <= req_adjust;
         in_item_ff.enabled    <= req_enabled;
      end
      if (go) begin
         out_target_valid_ff <= res_target_valid;
         out_target_mv_ff    <= res_target_mv;
         out_mode_cc_ff      <= res_mode_cc;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_target_valid = out_target_valid_ff;
   assign rsp_target_mv    = out_target_mv_ff;
   assign rsp_mode_cc      = out_mode_cc_ff;

endmodule

// File: tb/sv/cc_cv_supply_regulator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cc_cv_supply_regulator_top_tb
// Self-checking bench for the constant-current / constant-voltage regulator.
// A directed set of items covers the mode boundaries, the clamp and the
// saturation of the PID sum. Several register settings then follow with runs
// of random items around the current limit. Both handshake sides idle at
// random, and the result side is held off once for a long stretch. Every
// result is compared with an in-order prediction of the regulator.
// ----------------------------------------------------------------------------
module cc_cv_supply_regulator_top_tb
   import ccsr_pkg::*;
();

   localparam int NUM_PHASES      = 8;
   localparam int EVENTS_PER_SET  = 85;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam longint ACC_MAX     = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN     = -(longint'(1) <<< (ACC_W - 1));

   typedef struct packed {
      logic              target_valid;
      logic [DATA_W-1:0] target_mv;
      logic              mode_cc;
   } result_type;

   class regulator_tracker;
      cfg_type                 cfg;
      logic signed [ERR_W-1:0] err_last;
      logic signed [ERR_W-1:0] err_older;
      logic signed [ACC_W-1:0] pid_sum;
      logic                    mode_cc;
      result_type              due[$];
      int                      failures;
      int                      checked;
      int                      cc_seen;
      int                      targets_seen;

      function new();
         cfg = CFG_RESET;
         err_last = '0;
         err_older = '0;
         pid_sum = '0;
         mode_cc = 1'b0;
         failures = 0;
         checked = 0;
         cc_seen = 0;
         targets_seen = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_GAIN_PROP:       cfg.gain_prop = val;
            CSR_GAIN_INTEG:      cfg.gain_integ = val;
            CSR_GAIN_DERIV:      cfg.gain_deriv = val;
            CSR_CURRENT_LIMIT:   cfg.current_limit_ma = val;
            CSR_VOLTAGE_SETP:    cfg.voltage_setpoint_mv = val;
            CSR_VOLTAGE_FLOOR:   cfg.voltage_floor_mv = val;
            CSR_VOLTAGE_CEILING: cfg.voltage_ceiling_mv = val;
            CSR_CURRENT_HYST:    cfg.current_hysteresis_ma = val;
            default: ;
         endcase
      endfunction

      function result_type regulate(item_type it);
         result_type r;
         longint cur, volt, lim, setp, hyst, lo_mv, hi_mv;
         longint kp, ki, kd, e, acc, tgt, diff;
         r = '0;
         cur = it.current_ma;
         volt = it.voltage_mv;
         lim = cfg.current_limit_ma;
         setp = cfg.voltage_setpoint_mv;
         hyst = cfg.current_hysteresis_ma;
         lo_mv = cfg.voltage_floor_mv;
         hi_mv = cfg.voltage_ceiling_mv;
         kp = cfg.gain_prop;
         ki = cfg.gain_integ;
         kd = cfg.gain_deriv;
         if (it.adjust && it.enabled) begin
            if (cur > lim) begin
               mode_cc = 1'b1;
               e = lim - cur;
               acc = pid_sum + (kp + ki + kd) * e - (kp + 2 * kd) * err_last
                     + kd * err_older;
               if (acc > ACC_MAX) acc = ACC_MAX;
               if (acc < ACC_MIN) acc = ACC_MIN;
               pid_sum = acc[ACC_W-1:0];
               err_older = err_last;
               err_last = e[ERR_W-1:0];
               tgt = volt + (acc >>> GAIN_FRAC_BITS);
               if (tgt < lo_mv) tgt = lo_mv;
               if (tgt > hi_mv) tgt = hi_mv;
               r.target_valid = 1'b1;
               r.target_mv = tgt[DATA_W-1:0];
            end else if (cur < lim - hyst) begin
               mode_cc = 1'b0;
               err_last = '0;
               err_older = '0;
               pid_sum = '0;
               diff = volt - setp;
               if (diff < 0) diff = -diff;
               if (diff > VOLTAGE_STEP_MV) begin
                  r.target_valid = 1'b1;
                  r.target_mv = setp[DATA_W-1:0];
               end
            end else begin
               mode_cc = 1'b0;
               if (setp < volt) begin
                  r.target_valid = 1'b1;
                  r.target_mv = setp[DATA_W-1:0];
               end
            end
         end
         r.mode_cc = mode_cc;
         return r;
      endfunction

      function void note_event(item_type it);
         due.push_back(regulate(it));
      endfunction

      function void check_result(logic tv, logic [DATA_W-1:0] tmv, logic mcc);
         result_type want;
         if (due.size() == 0) begin
            $error("result arrived with no item outstanding");
            failures++;
            return;
         end
         want = due.pop_front();
         checked++;
         if (mcc) cc_seen++;
         if (tv) targets_seen++;
         if (tv !== want.target_valid) begin
            $error("target_valid: expected %0d, got %0d", want.target_valid, tv);
            failures++;
         end
         if (tmv !== want.target_mv) begin
            $error("target_mv: expected %0d, got %0d", want.target_mv, tmv);
            failures++;
         end
         if (mcc !== want.mode_cc) begin
            $error("mode_cc: expected %0d, got %0d", want.mode_cc, mcc);
            failures++;
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_en;
   logic [2:0]        csr_index;
   logic [DATA_W-1:0] csr_wdata;
   logic              req_valid;
   logic              req_stall;
   logic [DATA_W-1:0] req_current_ma;
   logic [DATA_W-1:0] req_voltage_mv;
   logic              req_adjust;
   logic              req_enabled;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_target_valid;
   logic [DATA_W-1:0] rsp_target_mv;
   logic              rsp_mode_cc;

   regulator_tracker book = new();
   bit sender_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit rsp_hold_req = 1'b0;
   int events_sent = 0;
   int requests_sent = 0;
   int settings_used = 1;

   cc_cv_supply_regulator_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_current_ma   (req_current_ma),
      .req_voltage_mv   (req_voltage_mv),
      .req_adjust       (req_adjust),
      .req_enabled      (req_enabled),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target_valid (rsp_target_valid),
      .rsp_target_mv    (rsp_target_mv),
      .rsp_mode_cc      (rsp_mode_cc)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic item_type make_event(longint cur, longint volt, bit adj, bit en);
      item_type it;
      if (cur < 0) cur = 0;
      if (cur > 65535) cur = 65535;
      if (volt < 0) volt = 0;
      if (volt > 65535) volt = 65535;
      it.current_ma = cur[DATA_W-1:0];
      it.voltage_mv = volt[DATA_W-1:0];
      it.adjust = adj;
      it.enabled = en;
      return it;
   endfunction

   function automatic item_type random_event(int region);
      longint lim, hyst, setp, cur, volt;
      bit [1:0] ctl;
      lim = book.cfg.current_limit_ma;
      hyst = book.cfg.current_hysteresis_ma;
      setp = book.cfg.voltage_setpoint_mv;
      if (region < 4) cur = lim + longint'($urandom_range(1, 3000));
      else if (region < 6) cur = lim - hyst - longint'($urandom_range(1, 3000));
      else if (region < 8) cur = lim - longint'($urandom_range(0, int'(hyst)));
      else cur = $urandom_range(0, 65535);
      if ($urandom_range(0, 1)) volt = setp + longint'($urandom_range(0, 400)) - 200;
      else volt = $urandom_range(0, 65535);
      if ($urandom_range(0, 99) < 88) ctl = 2'b11;
      else ctl = 2'($urandom_range(0, 2));
      return make_event(cur, volt, ctl[1], ctl[0]);
   endfunction

   function automatic logic [DATA_W-1:0] random_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 6) return DATA_W'($urandom_range(0, 1023));
      return DATA_W'($urandom_range(0, 65535));
   endfunction

   function automatic cfg_type random_cfg(int phase);
      cfg_type c;
      int r;
      if (phase == 0) return '1;
      if (phase == 1) return '0;
      c.gain_prop = random_gain();
      c.gain_integ = random_gain();
      c.gain_deriv = random_gain();
      c.current_limit_ma = DATA_W'($urandom_range(500, 60000));
      c.voltage_setpoint_mv = DATA_W'($urandom_range(0, 65535));
      c.voltage_floor_mv = DATA_W'($urandom_range(0, 20000));
      if ($urandom_range(0, 99) < 15)
         c.voltage_ceiling_mv = DATA_W'($urandom_range(0, c.voltage_floor_mv));
      else
         c.voltage_ceiling_mv = DATA_W'($urandom_range(c.voltage_floor_mv, 65535));
      r = $urandom_range(0, 99);
      if (r < 20) c.current_hysteresis_ma = '0;
      else if (r < 35)
         c.current_hysteresis_ma = DATA_W'($urandom_range(c.current_limit_ma, 65535));
      else c.current_hysteresis_ma = DATA_W'($urandom_range(1, 3000));
      return c;
   endfunction

   task automatic offer_event(input item_type it);
      int gap;
      req_valid <= 1'b1;
      req_current_ma <= it.current_ma;
      req_voltage_mv <= it.voltage_mv;
      req_adjust <= it.adjust;
      req_enabled <= it.enabled;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_event(it);
      events_sent++;
      if (it.adjust && it.enabled) requests_sent++;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      book.write_reg(idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      drain();
      put_reg(CSR_GAIN_PROP, c.gain_prop);
      put_reg(CSR_GAIN_INTEG, c.gain_integ);
      put_reg(CSR_GAIN_DERIV, c.gain_deriv);
      put_reg(CSR_CURRENT_LIMIT, c.current_limit_ma);
      put_reg(CSR_VOLTAGE_SETP, c.voltage_setpoint_mv);
      put_reg(CSR_VOLTAGE_FLOOR, c.voltage_floor_mv);
      put_reg(CSR_VOLTAGE_CEILING, c.voltage_ceiling_mv);
      put_reg(CSR_CURRENT_HYST, c.current_hysteresis_ma);
      csr_write_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_target_valid, rsp_target_mv, rsp_mode_cc);
   end

   initial begin : rsp_side
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            gap = pick_gap(rsp_calm);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      cfg_type c;
      int active;
      int region;
      int run_len;
      item_type it;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_GAIN_PROP;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_current_ma <= '0;
      req_voltage_mv <= '0;
      req_adjust <= 1'b0;
      req_enabled <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: limit 10000 mA, setpoint 3000 mV, unity gain, no band.
      offer_event(make_event(20000, 3000, 1'b0, 1'b1));
      offer_event(make_event(20000, 3000, 1'b1, 1'b0));
      offer_event(make_event(65535, 65535, 1'b0, 1'b0));
      offer_event(make_event(10000, 3100, 1'b1, 1'b1));
      offer_event(make_event(10000, 2900, 1'b1, 1'b1));
      offer_event(make_event(0, 0, 1'b1, 1'b1));
      offer_event(make_event(5000, 3050, 1'b1, 1'b1));
      offer_event(make_event(5000, 3051, 1'b1, 1'b1));
      offer_event(make_event(10001, 3000, 1'b1, 1'b1));
      offer_event(make_event(12000, 3000, 1'b1, 1'b1));
      offer_event(make_event(65535, 0, 1'b1, 1'b1));
      offer_event(make_event(65535, 65535, 1'b1, 1'b1));
      offer_event(make_event(10000, 2000, 1'b1, 1'b1));
      offer_event(make_event(65535, 100, 1'b1, 1'b1));
      offer_event(make_event(9999, 3000, 1'b1, 1'b1));

      // Floor above ceiling, band wider than the limit, largest gains.
      c = '1;
      c.current_limit_ma = 16'd10000;
      c.voltage_setpoint_mv = '0;
      c.voltage_floor_mv = 16'd4000;
      c.voltage_ceiling_mv = 16'd2000;
      c.current_hysteresis_ma = 16'd20000;
      apply_config(c);
      offer_event(make_event(10001, 3000, 1'b1, 1'b1));
      offer_event(make_event(0, 65535, 1'b1, 1'b1));
      repeat (4) offer_event(make_event(65535, 0, 1'b1, 1'b1));
      offer_event(make_event(0, 0, 1'b1, 1'b1));

      // All limits but the voltage floor at the top of their range, floor at zero, no gain.
      c = '1;
      c.gain_prop = '0;
      c.gain_integ = '0;
      c.gain_deriv = '0;
      c.voltage_floor_mv = '0;
      apply_config(c);
      offer_event(make_event(65535, 65535, 1'b1, 1'b1));
      offer_event(make_event(0, 0, 1'b1, 1'b1));
      offer_event(make_event(0, 65535, 1'b1, 1'b1));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         apply_config(random_cfg(phase));
         sender_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            sender_calm = 1'b1;
            rsp_calm = 1'b0;
            rsp_hold_req = 1'b1;
         end
         active = 0;
         while (active < EVENTS_PER_SET) begin
            region = $urandom_range(0, 9);
            run_len = $urandom_range(1, 12);
            repeat (run_len) begin
               it = random_event(region);
               offer_event(it);
               if (it.adjust && it.enabled) active++;
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d items (%0d regulation requests) under %0d register settings.",
               events_sent, requests_sent, settings_used);
      $display("Checked %0d results: %0d in constant-current mode, %0d with a new target.",
               book.checked, book.cc_seen, book.targets_seen);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
